// ===== src/bpa_pkg.sv =====
// shared constants, status codes and helpers of the buddy page allocator
// no dependencies
package bpa_pkg;

    localparam int MAX_PAGES = 512;
    localparam int NODE_W    = $clog2(2 * MAX_PAGES);
    localparam int TREE_D    = 2 ** NODE_W;
    localparam int SIZE_W    = $clog2(MAX_PAGES) + 1;
    localparam int OFF_W     = 9;
    localparam int CNT_W     = 10;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_BAD_REQ   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // smallest power of two not below v, for v up to 1024 (v of zero gives one)
    function automatic logic [CNT_W:0] round_pow2(input logic [CNT_W:0] v);
        logic [CNT_W:0] p;
        p = (CNT_W + 1)'(1);
        for (int i = 0; i < CNT_W; i++) begin
            if (v > ((CNT_W + 1)'(1) << i)) begin
                p = (CNT_W + 1)'(1) << (i + 1);
            end
        end
        return p;
    endfunction

    // pool size from a register value: clamp to 1..MAX_PAGES, then round up
    function automatic logic [SIZE_W-1:0] pool_from_cfg(input logic [CNT_W-1:0] v);
        logic [CNT_W:0] c;
        c = {1'b0, v};
        if (c == '0) begin
            c = (CNT_W + 1)'(1);
        end
        if (c > (CNT_W + 1)'(MAX_PAGES)) begin
            c = (CNT_W + 1)'(MAX_PAGES);
        end
        return SIZE_W'(round_pow2(c));
    endfunction

endpackage

// ===== src/bpa_ram.sv =====
// generic simple ram: one write port, two registered read ports
// no dependencies
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== src/buddy_page_allocator_top.sv =====
// buddy page allocator: longest-free-block tree kept in one ram
// depends on bpa_pkg and bpa_ram
//
// flow: one request at a time; an allocate walks down and back up the tree, a
//   free climbs from its leaf to the claimed block and on to the root, one level
//   per cycle through the ram read ports; the next request is taken once the
//   result is loaded into the output register, later while the result output is stalled
// reset: synchronous active low; the pool returns to 512 pages and a rebuild
//   sweep writes all 2*pool-1 tree nodes (1023 at 512 pages) before the first
//   request; each write of the pool size starts the same sweep over the new pool
module buddy_page_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: managed_pages
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] page_count, [18:10] page_offset, rest zero
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] block_offset, [18:9] block_pages, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_ACHK, S_DOWN, S_FSRCH, S_UP, S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_pool, n_pool;
    logic [NODE_W-1:0]  r_idx, n_idx;      // current tree node
    logic [SIZE_W-1:0]  r_size, n_size;    // size of the current node
    logic [SIZE_W-1:0]  r_val, n_val;      // value just written at r_idx
    logic               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [OFF_W-1:0]   r_offset, n_offset;
    logic [CNT_W:0]     r_want, n_want;    // rounded allocate size
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    logic [SIZE_W-1:0]  r_res_pages, n_res_pages;
    t_status            r_res_st, n_res_st;
    logic               r_m_valid, n_m_valid;
    logic [23:0]        r_m_data, n_m_data;
    logic [1:0]         r_m_user, n_m_user;

    // tree ram ports
    logic               mem_we;
    logic [NODE_W-1:0]  mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [SIZE_W-1:0]  mem_wdata, rd_a, rd_b;

    bpa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (TREE_D)
    ) u_tree (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    // scratch values of the walk
    logic [NODE_W:0]    sw_next;      // sweep index plus two, for level change
    logic [NODE_W:0]    sw_last;      // last node of the active tree
    logic [NODE_W-1:0]  leaf;
    logic [NODE_W-1:0]  pick, other, parent, sib;
    logic [SIZE_W-1:0]  pick_v, other_v, csize, sib_v, up_v;
    logic [SIZE_W:0]    up_sum;
    logic [NODE_W+SIZE_W:0] prod;

    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_idx       = r_idx;
        n_size      = r_size;
        n_val       = r_val;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_offset    = r_offset;
        n_want      = r_want;
        n_res_off   = r_res_off;
        n_res_pages = r_res_pages;
        n_res_st    = r_res_st;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;

        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = '0;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        sw_next = {1'b0, r_idx} + (NODE_W + 1)'(2);
        sw_last = {r_pool, 1'b0} - (NODE_W + 1)'(2);
        leaf    = NODE_W'(s_tdata[18:10]) + NODE_W'(r_pool) - NODE_W'(1);

        // descent: take the fitting child with the smaller free block
        if (rd_a <= rd_b) begin
            pick = NODE_W'({r_idx, 1'b1});  pick_v = rd_a;
            other = pick + NODE_W'(1);      other_v = rd_b;
        end else begin
            pick = NODE_W'({r_idx, 1'b0}) + NODE_W'(2);  pick_v = rd_b;
            other = pick - NODE_W'(1);                   other_v = rd_a;
        end
        if (r_want > {1'b0, pick_v}) begin
            pick = other;
            pick_v = other_v;
        end
        csize = r_size >> 1;

        // climb: parent from the sibling just read and the value just written
        parent = (r_idx - NODE_W'(1)) >> 1;
        sib    = r_idx[0] ? (r_idx + NODE_W'(1)) : (r_idx - NODE_W'(1));
        sib_v  = rd_a;
        up_sum = {1'b0, r_val} + {1'b0, sib_v};
        if (r_cmd == CMD_FREE && up_sum == {r_size, 1'b0}) begin
            up_v = SIZE_W'({r_size, 1'b0});
        end else begin
            up_v = (r_val > sib_v) ? r_val : sib_v;
        end

        prod = '0;

        // output register drains first, a finished result may load it below
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_size;
                if ({1'b0, r_idx} == sw_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + NODE_W'(1);
                    if ((sw_next & (sw_next - (NODE_W + 1)'(1))) == '0) begin
                        n_size = r_size >> 1;
                    end
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    n_cmd    = s_tuser;
                    n_count  = s_tdata[9:0];
                    n_offset = s_tdata[18:10];
                    n_want   = round_pow2({1'b0, s_tdata[9:0]});
                    if (s_tuser == CMD_FREE) begin
                        mem_raddr_a = leaf;
                        n_idx       = leaf;
                        n_size      = SIZE_W'(1);
                        n_state     = S_FSRCH;
                    end else begin
                        mem_raddr_a = '0;
                        n_state     = S_ACHK;
                    end
                end
            end

            S_ACHK: begin
                n_res_off   = '0;
                n_res_pages = '0;
                if (r_count == '0) begin
                    n_res_st = ST_BAD_REQ;
                    n_state  = S_FIN;
                end else if (r_count > CNT_W'(r_pool) || r_want > {1'b0, rd_a}) begin
                    n_res_st = ST_NO_ROOM;
                    n_state  = S_FIN;
                end else if (r_want == {1'b0, r_pool}) begin
                    // whole pool in one block
                    mem_we      = 1'b1;
                    mem_waddr   = '0;
                    mem_wdata   = '0;
                    n_res_pages = r_pool;
                    n_res_st    = ST_DONE;
                    n_state     = S_FIN;
                end else begin
                    mem_raddr_a = NODE_W'(1);
                    mem_raddr_b = NODE_W'(2);
                    n_idx       = '0;
                    n_size      = r_pool;
                    n_state     = S_DOWN;
                end
            end

            S_DOWN: begin
                if ({1'b0, csize} == r_want) begin
                    mem_we      = 1'b1;
                    mem_waddr   = pick;
                    mem_wdata   = '0;
                    prod        = ({1'b0, pick} + (NODE_W + 1)'(1)) * csize;
                    n_res_off   = OFF_W'(prod - (NODE_W + SIZE_W + 1)'(r_pool));
                    n_res_pages = csize;
                    n_res_st    = ST_DONE;
                    mem_raddr_a = pick[0] ? (pick + NODE_W'(1)) : (pick - NODE_W'(1));
                    n_val       = '0;
                    n_idx       = pick;
                    n_size      = csize;
                    n_state     = S_UP;
                end else begin
                    mem_raddr_a = NODE_W'({pick, 1'b1});
                    mem_raddr_b = NODE_W'({pick, 1'b0}) + NODE_W'(2);
                    n_idx       = pick;
                    n_size      = csize;
                end
            end

            S_FSRCH: begin
                if (SIZE_W'(r_offset) >= r_pool) begin
                    n_res_off   = '0;
                    n_res_pages = '0;
                    n_res_st    = ST_BAD_REQ;
                    n_state     = S_FIN;
                end else if (rd_a != '0) begin
                    if (r_idx == '0) begin
                        // nothing claimed on the path to the root
                        n_res_off   = '0;
                        n_res_pages = '0;
                        n_res_st    = ST_NOT_ALLOC;
                        n_state     = S_FIN;
                    end else begin
                        mem_raddr_a = parent;
                        n_idx       = parent;
                        n_size      = r_size << 1;
                    end
                end else begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_idx;
                    mem_wdata   = r_size;
                    prod        = ({1'b0, r_idx} + (NODE_W + 1)'(1)) * r_size;
                    n_res_off   = OFF_W'(prod - (NODE_W + SIZE_W + 1)'(r_pool));
                    n_res_pages = r_size;
                    n_res_st    = ST_DONE;
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        mem_raddr_a = sib;
                        n_val       = r_size;
                        n_state     = S_UP;
                    end
                end
            end

            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = up_v;
                if (parent == '0) begin
                    n_state = S_FIN;
                end else begin
                    // siblings off the path are not touched by this walk
                    mem_raddr_a = parent[0] ? (parent + NODE_W'(1))
                                            : (parent - NODE_W'(1));
                    n_idx  = parent;
                    n_val  = up_v;
                    n_size = r_size << 1;
                end
            end

            S_FIN: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {5'd0, r_res_pages, r_res_off};
                    n_m_user  = r_res_st;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new pool size rebuilds the tree
        if (i_cfg_we) begin
            n_pool  = pool_from_cfg(i_cfg_data);
            n_idx   = '0;
            n_size  = pool_from_cfg(i_cfg_data);
            n_state = S_SWEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_pool    <= SIZE_W'(MAX_PAGES);
            r_idx     <= '0;
            r_size    <= SIZE_W'(MAX_PAGES);
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pool    <= n_pool;
            r_idx     <= n_idx;
            r_size    <= n_size;
            r_m_valid <= n_m_valid;
        end
        r_val       <= n_val;
        r_cmd       <= n_cmd;
        r_count     <= n_count;
        r_offset    <= n_offset;
        r_want      <= n_want;
        r_res_off   <= n_res_off;
        r_res_pages <= n_res_pages;
        r_res_st    <= n_res_st;
        r_m_data    <= n_m_data;
        r_m_user    <= n_m_user;
    end

endmodule

// ===== dv/buddy_page_allocator_checker.sv =====
// checker for the buddy page allocator: watches both streams, predicts results
// with its own copy of the longest-free tree and compares; depends on bpa_pkg
`timescale 1ns / 1ps

module buddy_page_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    import bpa_pkg::*;

    typedef struct packed {
        logic [8:0] offset;
        logic [9:0] pages;
        t_status    status;
    } t_result;

    int unsigned tree [0:2*MAX_PAGES-2];
    int unsigned pool;
    t_result     expected_results [$];

    function automatic int unsigned pow2_ceil(input int unsigned v);
        int unsigned p;
        p = 1;
        while (p < v) p = p << 1;
        return p;
    endfunction

    task automatic rebuild_tree(input logic [9:0] cfg);
        int unsigned v;
        int unsigned nsz;
        v = 32'(cfg);
        if (v == 0) v = 1;
        if (v > MAX_PAGES) v = MAX_PAGES;
        pool = pow2_ceil(v);
        nsz = pool * 2;
        for (int unsigned i = 0; i < 2 * pool - 1; i++) begin
            if (((i + 1) & i) == 0) nsz = nsz >> 1;
            tree[i] = nsz;
        end
    endtask

    function automatic t_result mk(input int unsigned off, input int unsigned pg,
                                   input t_status st);
        t_result r;
        r.offset = off[8:0];
        r.pages  = pg[9:0];
        r.status = st;
        return r;
    endfunction

    function automatic t_result predict_alloc(input int unsigned count);
        int unsigned want, idx, nsz, l, r, pick, off;
        idx = 0;
        if (count == 0) return mk(0, 0, ST_BAD_REQ);
        want = pow2_ceil(count);
        if (count > pool || tree[0] < want) return mk(0, 0, ST_NO_ROOM);
        for (nsz = pool; nsz != want; nsz = nsz >> 1) begin
            l = 2 * idx + 1;
            r = 2 * idx + 2;
            pick = (tree[l] <= tree[r]) ? l : r;
            if (want > tree[pick]) pick = (pick == l) ? r : l;
            idx = pick;
        end
        tree[idx] = 0;
        off = (idx + 1) * nsz - pool;
        while (idx != 0) begin
            idx = (idx - 1) >> 1;
            tree[idx] = (tree[2*idx+1] > tree[2*idx+2]) ? tree[2*idx+1] : tree[2*idx+2];
        end
        return mk(off, nsz, ST_DONE);
    endfunction

    function automatic t_result predict_free(input int unsigned offset);
        int unsigned idx, nsz, start, blk, lv, rv;
        nsz = 1;
        if (offset >= pool) return mk(0, 0, ST_BAD_REQ);
        idx = offset + pool - 1;
        while (tree[idx] != 0) begin
            if (idx == 0) return mk(0, 0, ST_NOT_ALLOC);
            idx = (idx - 1) >> 1;
            nsz = nsz << 1;
        end
        blk = nsz;
        start = (idx + 1) * nsz - pool;
        tree[idx] = nsz;
        while (idx != 0) begin
            idx = (idx - 1) >> 1;
            nsz = nsz << 1;
            lv = tree[2*idx+1];
            rv = tree[2*idx+2];
            // buddies both whole merge into one block
            if (lv + rv == nsz) tree[idx] = nsz;
            else tree[idx] = (lv > rv) ? lv : rv;
        end
        return mk(start, blk, ST_DONE);
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            rebuild_tree(10'd512);
            expected_results.delete();
            o_fail_count   <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) rebuild_tree(i_cfg_data);
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_ALLOC)
                    expected_results.push_back(predict_alloc(32'(s_tdata[9:0])));
                else
                    expected_results.push_back(predict_free(32'(s_tdata[18:10])));
            end
            if (m_tvalid && m_tready) begin
                got.offset = m_tdata[8:0];
                got.pages  = m_tdata[18:9];
                got.status = t_status'(m_tuser);
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.offset !== exp_r.offset || got.pages !== exp_r.pages ||
                        got.status !== exp_r.status || m_tdata[23:19] !== '0) begin
                        if (got.offset !== exp_r.offset)
                            $error("block_offset expected %0d got %0d", exp_r.offset, got.offset);
                        if (got.pages !== exp_r.pages)
                            $error("block_pages expected %0d got %0d", exp_r.pages, got.pages);
                        if (got.status !== exp_r.status)
                            $error("status expected %0d got %0d", exp_r.status, got.status);
                        if (m_tdata[23:19] !== '0)
                            $error("tdata pad expected 0 got %0h", m_tdata[23:19]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/buddy_page_allocator_top_tb.sv =====
// testbench top for the buddy page allocator: clock, reset, request stimulus,
// result stalls and verdict; depends on bpa_pkg, the block and the checker
`timescale 1ns / 1ps

module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    localparam int IDLE_LIMIT  = 5000;   // covers the rebuild sweep at 512 pages
    localparam int LONG_STALL  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;       // [9:0] page_count, [18:10] page_offset
    logic        s_tuser = 1'b0;     // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [8:0] block_offset, [18:9] block_pages
    logic [1:0]  m_tuser;            // [1:0] status

    int fail_count, pending, results_seen;
    int idle_cycles;
    int requests_sent;
    int settings_used;
    bit hold_results;                // long receiver hold-off
    bit stall_mode;                  // false gives a no-stall stretch
    int unsigned cur_pool;

    // live block offsets, so frees mostly hit claimed blocks
    logic [8:0] live_blocks [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buddy_page_allocator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    buddy_page_allocator_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // track block offsets of successful results on the result stream, frees included
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready && m_tuser == ST_DONE && live_blocks.size() < 64)
            live_blocks.push_back(m_tdata[8:0]);
    end

    // receiver: own stall pattern, switchable, plus the long hold-off
    always @(negedge i_clk) begin
        if (hold_results) m_tready <= 1'b0;
        else if (!stall_mode) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog: cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("status: fail");
            $finish;
        end
    end

    // one request; valid held through accept, then an optional gap with valid low
    task automatic send_request(input logic cmd, input logic [9:0] count,
                                input logic [8:0] offset, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, offset, count};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_pool(input logic [9:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_pool = 32'(pool_from_cfg(value));
        live_blocks.delete();
        settings_used++;
    endtask

    // random traffic: mostly allocs of small sizes and frees of live blocks
    task automatic random_traffic(input int n);
        int burst;
        logic [9:0] cnt;
        logic [8:0] off;
        int pick;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            cnt = 10'($urandom());
            off = 9'($urandom());
            if (pick < 45) begin
                cnt = (pick < 5) ? 10'($urandom_range(0, 1023))
                                 : 10'($urandom_range(1, (cur_pool > 16) ? 16 : cur_pool));
                if (pick == 6) cnt = 10'($urandom_range(1, cur_pool));
            end else if (pick < 85 && live_blocks.size() > 0) begin
                // free a live block, sometimes at an inner page
                off = live_blocks[0];
                if ($urandom_range(0, 3) == 0) off = off + 9'($urandom_range(0, 1));
                void'(live_blocks.pop_front());
            end else if (pick >= 85) begin
                off = (pick < 92) ? 9'($urandom_range(0, cur_pool - 1)) : 9'($urandom());
            end
            if (burst == 0) burst = $urandom_range(1, 12);
            burst--;
            send_request((pick < 45) ? CMD_ALLOC : CMD_FREE, cnt, off,
                         (burst == 0) ? $urandom_range(1, 25) : 0);
        end
    endtask

    initial begin
        hold_results = 1'b0;
        stall_mode   = 1'b1;
        cur_pool     = 512;
        requests_sent = 0;
        settings_used = 1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both commands and each error case, pool of 512
        send_request(CMD_ALLOC, 10'd0, 9'd0, 0);       // zero count
        send_request(CMD_ALLOC, 10'd513, 9'h1ff, 0);   // count above pool
        send_request(CMD_ALLOC, 10'h3ff, 9'd0, 0);
        send_request(CMD_FREE, 10'h3ff, 9'd5, 0);      // nothing claimed
        send_request(CMD_ALLOC, 10'd512, 9'd0, 2);     // whole pool
        send_request(CMD_ALLOC, 10'd1, 9'd0, 0);       // no fitting block
        send_request(CMD_FREE, 10'd0, 9'd300, 0);      // inner offset frees whole
        send_request(CMD_ALLOC, 10'd3, 9'h1ff, 0);
        send_request(CMD_ALLOC, 10'd1, 9'd0, 0);
        send_request(CMD_ALLOC, 10'd257, 9'd0, 0);
        send_request(CMD_ALLOC, 10'd256, 9'd0, 0);
        send_request(CMD_FREE, 10'd0, 9'd2, 0);        // inside a 4 page block
        send_request(CMD_FREE, 10'd0, 9'd4, 0);
        send_request(CMD_FREE, 10'd0, 9'h1ff, 0);
        send_request(CMD_FREE, 10'd0, 9'd1, 0);

        // small pool: offset out of pool and zero register value
        write_pool(10'd0);
        send_request(CMD_FREE, 10'd0, 9'd1, 0);        // offset equal to pool
        send_request(CMD_ALLOC, 10'd2, 9'd0, 0);
        send_request(CMD_ALLOC, 10'd1, 9'd0, 0);
        send_request(CMD_FREE, 10'd0, 9'd0, 0);
        random_traffic(40);

        write_pool(10'd5);
        send_request(CMD_FREE, 10'd0, 9'd8, 0);
        random_traffic(120);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_results = 1'b1;
                repeat (LONG_STALL) @(posedge i_clk);
                hold_results = 1'b0;
            end
            random_traffic(30);
        join
        drain_results();                                // sender waits for all results

        write_pool(10'd1023);                           // clamps to 512
        stall_mode = 1'b0;
        random_traffic(150);
        stall_mode = 1'b1;
        random_traffic(150);

        write_pool(10'd1);
        random_traffic(40);
        write_pool(10'd100);
        random_traffic(150);
        write_pool(10'd512);
        random_traffic(200);

        drain_results();
        repeat (50) @(negedge i_clk);
        $display("covered %0d requests, %0d results, %0d pool settings incl. 1 and 512",
                 requests_sent, results_seen, settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
